/* rtl/nsr_pkg.sv */
// shared types and constants for the newton square root unit
// used by nsr_div and newton_square_root_unit; depends on nothing
package nsr_pkg;

  localparam int IN_W   = 32;
  localparam int ROOT_W = 24;

  localparam logic [ROOT_W-1:0] ROOT_MAX = {ROOT_W{1'b1}};

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BAD   = 2'd1,
    ST_LIMIT = 2'd2
  } status_t;

  // divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

/* rtl/nsr_div.sv */
// restoring unsigned divider, one quotient bit per cycle
// depends on nsr_pkg for the status struct
module nsr_div #(
  parameter int W = 47
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [W-1:0]         num,
  input  logic [W-1:0]         den,
  output logic [W-1:0]         quo,
  output nsr_pkg::div_status_t st
);
  import nsr_pkg::*;

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem;
  logic [W-1:0]  num_sh;
  logic [W-1:0]  den_r;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;

  logic [W:0]    shifted;
  logic [W:0]    diff;
  logic          ge;
  logic [W-1:0]  rem_next;

  // one trial subtraction per cycle
  assign shifted  = {rem, num_sh[W-1]};
  assign diff     = shifted - {1'b0, den_r};
  assign ge       = shifted >= {1'b0, den_r};
  assign rem_next = ge ? diff[W-1:0] : shifted[W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem    <= '0;
        num_sh <= num;
        den_r  <= den;
        cnt    <= CW'(W);
        busy   <= 1'b1;
      end else if (busy) begin
        rem    <= rem_next;
        num_sh <= {num_sh[W-2:0], ge};
        cnt    <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient bits have shifted fully into num_sh when done
  assign quo     = num_sh;
  assign st.busy = busy;
  assign st.done = done;

endmodule

/* rtl/newton_square_root_unit.sv */
// newton square root unit: sequencer around a shared bit-serial divider
// depends on nsr_pkg and nsr_div
//
// Takes a signed fixed-point radicand and tolerance (FRAC_BITS fraction bits)
// and returns one unsigned root with a status code (ok, bad argument, iteration
// limit). One item is in flight at a time; in_stall is low only while idle.
// A bad argument or a zero radicand raises out_valid in the cycle after the transfer.
// Otherwise each Newton step passes through a start state, the divider run (the
// restoring divider yields one quotient bit per cycle), the done flag and an
// update state; an item takes at most MAX_ITERATIONS steps. The result
// register holds until the output transfer.
module newton_square_root_unit #(
  parameter int FRAC_BITS      = 16,
  parameter int MAX_ITERATIONS = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [31:0]       radicand,
  input  logic signed [31:0]       tolerance,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [23:0]              root,
  output logic [1:0]               status
);
  import nsr_pkg::*;

  // guesses and quotients never exceed radicand << FRAC_BITS
  localparam int XW = IN_W - 1 + FRAC_BITS;
  localparam int IW = $clog2(MAX_ITERATIONS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_DIV,
    S_UPDATE,
    S_OUT
  } state_t;

  state_t          state;
  logic [IN_W-2:0] a_r;
  logic [IN_W-1:0] tol_r;
  logic [XW-1:0]   x;
  logic [IW-1:0]   iter;
  logic [ROOT_W-1:0] root_r;
  status_t         status_r;

  logic            in_xfer;
  logic            bad_arg;
  logic            zero_arg;
  logic [XW-1:0]   first_guess;

  logic            div_start;
  logic [XW-1:0]   div_num;
  logic [XW-1:0]   quo;
  div_status_t     div_st;

  logic [XW:0]     sum;
  logic [XW-1:0]   nx;
  logic [XW-1:0]   step_diff;
  logic            close;
  logic [XW-1:0]   nx_fix;
  logic            last_iter;

  function automatic logic [ROOT_W-1:0] sat_root(input logic [XW-1:0] v);
    logic [ROOT_W-1:0] r;
    if (v[XW-1:ROOT_W] != '0) begin
      r = ROOT_MAX;
    end else begin
      r = v[ROOT_W-1:0];
    end
    return r;
  endfunction

  // argument screening at the input transfer
  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign bad_arg  = radicand[IN_W-1] || tolerance[IN_W-1] || (tolerance == '0) ||
                    ((tolerance >>> FRAC_BITS) != '0);
  assign zero_arg = (radicand == '0);

  // first guess is radicand / 2, bumped to one lsb if it truncates to zero
  assign first_guess = (radicand[IN_W-2:1] == '0) ? XW'(1) :
                       XW'(radicand[IN_W-2:1]);

  // shared divider computes (a << FRAC_BITS) / x
  assign div_start = (state == S_START);
  assign div_num   = {a_r, {FRAC_BITS{1'b0}}};

  nsr_div #(
    .W (XW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (x),
    .quo   (quo),
    .st    (div_st)
  );

  // newton update and stopping test
  assign sum       = {1'b0, quo} + {1'b0, x};
  assign nx        = sum[XW:1];
  assign step_diff = (nx >= x) ? (nx - x) : (x - nx);
  assign close     = step_diff <= {{(XW-IN_W){1'b0}}, tol_r};
  assign nx_fix    = (nx == '0) ? XW'(1) : nx;
  assign last_iter = (iter == IW'(MAX_ITERATIONS - 1));

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      iter      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            a_r   <= radicand[IN_W-2:0];
            tol_r <= tolerance;
            x     <= first_guess;
            iter  <= '0;
            if (bad_arg) begin
              root_r    <= '0;
              status_r  <= ST_BAD;
              out_valid <= 1'b1;
              state     <= S_OUT;
            end else if (zero_arg) begin
              root_r    <= '0;
              status_r  <= ST_OK;
              out_valid <= 1'b1;
              state     <= S_OUT;
            end else begin
              state <= S_START;
            end
          end
        end
        S_START: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_st.done) begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (close) begin
            root_r    <= sat_root(nx);
            status_r  <= ST_OK;
            out_valid <= 1'b1;
            state     <= S_OUT;
          end else begin
            x    <= nx_fix;
            iter <= iter + 1'b1;
            if (last_iter) begin
              root_r    <= sat_root(nx_fix);
              status_r  <= ST_LIMIT;
              out_valid <= 1'b1;
              state     <= S_OUT;
            end else begin
              state <= S_START;
            end
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: begin
          out_valid <= 1'b0;
          state     <= S_IDLE;
        end
      endcase
    end
  end

  assign root   = root_r;
  assign status = status_r;

  // input is taken only when no result is pending
  a_idle_no_result: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !out_valid)
    else $error("input open while a result is pending");

  // bad argument results always carry a zero root
  a_bad_zero_root: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_BAD) |-> (root == '0))
    else $error("bad argument result with nonzero root");

  // divider is started only when it is free
  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_st.busy)
    else $error("divider started while busy");

  // a divider completion lands only while waiting for it
  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_st.done |-> (state == S_DIV))
    else $error("divider finished outside the wait state");

  // iteration count never passes the cap
  a_iter_cap: assert property (@(posedge clk) disable iff (rst)
    iter <= IW'(MAX_ITERATIONS))
    else $error("iteration counter passed the cap");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// testbench for newton_square_root_unit: random and directed radicand/tolerance transfers
// depends on nsr_pkg and newton_square_root_unit; scoreboard class holds predicted roots

// predicted roots, kept in transfer order
class root_scoreboard #(int FRAC = 16, int MAX_STEPS = 32);

  typedef struct packed {
    logic [nsr_pkg::ROOT_W-1:0] root;
    nsr_pkg::status_t           status;
  } root_result_t;

  root_result_t pending_roots[$];
  int           errors;

  function new();
    errors = 0;
  endfunction

  // fixed-point newton iteration, truncating division and halving
  function root_result_t predict_root(logic [31:0] rad, logic [31:0] tol);
    logic [63:0]  a, t, one, x, nx, q, gap, last;
    root_result_t res;
    bit           settled;
    int           step;
    a       = {32'd0, rad};
    t       = {32'd0, tol};
    one     = 64'd1 << FRAC;
    settled = 1'b0;
    // bad argument check comes first
    if (rad[31] || tol[31] || t == 64'd0 || t >= one) begin
      res.root   = '0;
      res.status = nsr_pkg::ST_BAD;
      return res;
    end
    if (a == 64'd0) begin
      res.root   = '0;
      res.status = nsr_pkg::ST_OK;
      return res;
    end
    // first guess a/2, a zero guess becomes the smallest step
    x          = a >> 1;
    if (x == 64'd0) x = 64'd1;
    last       = x;
    res.status = nsr_pkg::ST_LIMIT;
    for (step = 0; step < MAX_STEPS && !settled; step++) begin
      q    = (a << FRAC) / x;
      nx   = (q + x) >> 1;
      gap  = (nx >= x) ? nx - x : x - nx;
      if (gap <= t) begin
        last       = nx;
        res.status = nsr_pkg::ST_OK;
        settled    = 1'b1;
      end else begin
        x    = (nx == 64'd0) ? 64'd1 : nx;
        last = x;
      end
    end
    // saturate a root wider than the port
    if (last > {40'd0, nsr_pkg::ROOT_MAX}) res.root = nsr_pkg::ROOT_MAX;
    else res.root = last[nsr_pkg::ROOT_W-1:0];
    return res;
  endfunction

  function void note_input(logic [31:0] rad, logic [31:0] tol);
    pending_roots.push_back(predict_root(rad, tol));
  endfunction

  function void check_result(logic [nsr_pkg::ROOT_W-1:0] root, logic [1:0] status);
    root_result_t exp_res;
    if (pending_roots.size() == 0) begin
      $error("unexpected result transfer: root %h status %0d", root, status);
      errors++;
      return;
    end
    exp_res = pending_roots.pop_front();
    if (root !== exp_res.root) begin
      $error("root mismatch: expected %h, actual %h", exp_res.root, root);
      errors++;
    end
    if (status !== exp_res.status) begin
      $error("status mismatch: expected %0d, actual %0d", exp_res.status, status);
      errors++;
    end
  endfunction

  function int pending();
    return pending_roots.size();
  endfunction

endclass

module tb;

  localparam int FRAC_BITS      = 16;
  localparam int MAX_ITERATIONS = 32;
  localparam int ITEM_CYCLES    = 1 + MAX_ITERATIONS * (FRAC_BITS + 34);
  localparam int TAIL_CYCLES    = 2 * ITEM_CYCLES;
  localparam int WATCHDOG       = 10 * ITEM_CYCLES;
  localparam int RANDOM_ITEMS   = 600;
  localparam logic [31:0] ONE_FIX = 32'd1 << FRAC_BITS;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] radicand;
  logic [31:0] tolerance;
  logic        out_valid;
  logic        out_stall;
  logic [23:0] root;
  logic [1:0]  status;

  root_scoreboard #(FRAC_BITS, MAX_ITERATIONS) sb;

  bit idle_on;
  int quiet_cycles;

  newton_square_root_unit #(
    .FRAC_BITS      (FRAC_BITS),
    .MAX_ITERATIONS (MAX_ITERATIONS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .radicand  (radicand),
    .tolerance (tolerance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .root      (root),
    .status    (status)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // present one item, hold it until the transfer
  task automatic send_item(input logic [31:0] rad, input logic [31:0] tol);
    while (idle_on && $urandom_range(0, 99) < 10) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid  = 1'b1;
    radicand  = rad;
    tolerance = tol;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(rad, tol);
    @(negedge clk);
  endtask

  // hold off new items until every expected root has arrived
  task automatic drain_roots();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // result side stall
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall = idle_on && ($urandom_range(0, 99) < 10);
    end
  end

  // result check and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_result(root, status);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    logic [31:0] rad, tol;
    int          kind;
    sb           = new();
    idle_on      = 1'b1;
    quiet_cycles = 0;
    rst          = 1'b1;
    in_valid     = 1'b0;
    radicand     = '0;
    tolerance    = '0;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    // bad arguments: negative radicand, tolerance out of (0,1)
    send_item(32'h8000_0000, 32'd100);
    send_item(32'hFFFF_FFFF, 32'd100);
    send_item(32'h0001_0000, 32'd0);
    send_item(32'h0001_0000, 32'hFFFF_FFFF);
    send_item(32'h0001_0000, 32'h8000_0000);
    send_item(32'h0001_0000, ONE_FIX);
    send_item(32'h0001_0000, 32'h7FFF_FFFF);
    send_item(32'h0000_0000, 32'd0);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // zero radicand
    send_item(32'h0000_0000, 32'd1);
    send_item(32'h0000_0000, ONE_FIX - 1);
    // zero first guess
    send_item(32'h0000_0001, 32'd1);
    send_item(32'h0000_0001, ONE_FIX - 1);
    // small, exact and largest radicands
    send_item(32'h0000_0002, 32'd1);
    send_item(32'h0000_0003, 32'd1);
    send_item(32'h0001_0000, 32'd1);
    send_item(32'h0002_0000, 32'd1);
    send_item(32'h0004_0000, 32'd1);
    send_item(32'h7FFF_FFFF, 32'd1);
    send_item(32'h7FFF_FFFF, ONE_FIX - 1);
    send_item(32'h4000_0000, 32'd1);
    send_item(32'h0064_0000, 32'h0000_8000);
    drain_roots();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // a stretch with no idling on either side
      idle_on = !(n >= 200 && n < 350);
      if (n == 300) drain_roots();
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
        // well-formed item, radicand magnitude spread over all scales
        rad = $urandom >> $urandom_range(1, 31);
        if ($urandom_range(0, 9) == 0) rad = $urandom_range(0, 3);
        if ($urandom_range(0, 1) == 1) tol = $urandom_range(1, ONE_FIX - 1);
        else tol = $urandom_range(1, 16);
      end else if (kind < 90) begin
        // tolerance out of range
        rad = $urandom >> $urandom_range(1, 31);
        case ($urandom_range(0, 2))
          0: tol = 32'd0;
          1: tol = $urandom | 32'h8000_0000;
          default: tol = $urandom_range(ONE_FIX, 32'h7FFF_FFFF);
        endcase
      end else begin
        // raw noise on both fields
        rad = $urandom;
        tol = $urandom;
      end
      send_item(rad, tol);
    end
    in_valid = 1'b0;
    idle_on  = 1'b1;

    // wait for the last roots, then look for strays
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
